FILE: rtl/jhs_pkg.sv
`timescale 1ns / 1ps
// Types, codes and constants shared by the JFIF header scanner.
// No dependencies; every other file of the block imports this package.
package jhs_pkg;

    // Marker bytes and segment limits
    localparam logic [7:0] MARK_PREFIX  = 8'hFF;
    localparam logic [7:0] MARK_APP0    = 8'hE0;
    localparam logic [7:0] MARK_SOF0    = 8'hC0;
    localparam logic [7:0] APP0_MIN_LEN = 8'd16;

    // Field positions inside the APP0 body (counted from the identifier)
    localparam logic [4:0] APP0_IDENT_LEN = 5'd6;
    localparam logic [4:0] APP0_MINOR_IDX = 5'd6;
    localparam logic [4:0] APP0_XTH_IDX   = 5'd12;
    localparam logic [4:0] APP0_YTH_IDX   = 5'd13;
    localparam logic [7:0] JFIF_MINOR_MAX = 8'd1;

    // Field positions inside the SOF0 body (counted after the increment)
    localparam logic [4:0] SOF_HEIGHT_HI = 5'd4;
    localparam logic [4:0] SOF_HEIGHT_LO = 5'd5;
    localparam logic [4:0] SOF_WIDTH_HI  = 5'd6;
    localparam logic [4:0] SOF_WIDTH_LO  = 5'd7;
    localparam logic [4:0] SOF_NCOMP     = 5'd8;
    localparam logic [4:0] SOF_SAMP0     = 5'd10;
    localparam logic [4:0] SOF_SAMP1     = 5'd13;
    localparam logic [4:0] SOF_SAMP2     = 5'd16;
    localparam logic [7:0] SOF_FULL_COMPS = 8'd3;

    localparam logic [11:0] POS_MAX = 12'hFFF;

    // Result kinds
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    // Report status codes
    typedef enum logic [1:0] {
        ST_THUMB   = 2'd0,
        ST_FRAME   = 2'd1,
        ST_BAD_ID  = 2'd2,
        ST_NO_SIZE = 2'd3
    } t_status;

    // Parse phases, one-hot
    typedef enum logic [7:0] {
        PH_SCAN   = 8'b0000_0001,
        PH_MARK   = 8'b0000_0010,
        PH_LENHI  = 8'b0000_0100,
        PH_LENLO  = 8'b0000_1000,
        PH_APP0   = 8'b0001_0000,
        PH_SOF    = 8'b0010_0000,
        PH_PIXELS = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  component_count;
        logic [7:0]  sampling_first;
        logic [7:0]  sampling_second;
        logic [7:0]  sampling_third;
        logic [11:0] thumb_offset;
        logic [14:0] pixel_value;
        logic        last_pixel;
    } t_out_word;

    // Input register to parser
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_stage;

    // "JFIF", 0, major version 1
    function automatic logic [7:0] jhs_ident_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h4A;
            3'd1:    v = 8'h46;
            3'd2:    v = 8'h49;
            3'd3:    v = 8'h46;
            3'd4:    v = 8'h00;
            3'd5:    v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_out_word jhs_report(
        input t_status     st,
        input logic [15:0] w,
        input logic [15:0] h,
        input logic [7:0]  comps,
        input logic [7:0]  s0,
        input logic [7:0]  s1,
        input logic [7:0]  s2,
        input logic [11:0] off
    );
        t_out_word r;
        r                 = '0;
        r.result_kind     = KIND_REPORT;
        r.status          = st;
        r.image_width     = w;
        r.image_height    = h;
        r.component_count = comps;
        r.sampling_first  = s0;
        r.sampling_second = s1;
        r.sampling_third  = s2;
        r.thumb_offset    = off;
        return r;
    endfunction

endpackage

FILE: rtl/jhs_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the scanner: file bytes in, results out.
// Depends on jhs_pkg for the payload types.
interface jhs_byte_if;
    import jhs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface jhs_result_if;
    import jhs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/jfif_header_scan_thumbnail_unpack_core.sv
`timescale 1ns / 1ps
// Top level of the JFIF header scanner with thumbnail unpacker.
// Depends on jhs_pkg, jhs_if, jhs_in_stage and jhs_parser.

// Takes a JPEG file one byte word per cycle and reports either the embedded
// JFIF thumbnail (size and file offset, then every RGB888 pixel as RGB555)
// or the SOF0 frame size, components and sampling bytes; bad APP0 identifiers
// and files without a usable size give a status report. Throughput is one
// byte per clock: the whole parse step for a byte is combinational logic
// between the input register and the result register, and at most one
// result follows each byte. Back-pressure on the result side stalls the
// input once both registers are full. The user must write thumbnail_only
// only while no byte is in flight; the block itself does not enforce this.
module jfif_header_scan_thumbnail_unpack_core #(
    parameter int unsigned WINDOW_BYTES = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    jhs_byte_if.sink     i_byte_if,
    jhs_result_if.source o_result_if
);
    import jhs_pkg::*;

    t_stage w_stage;
    logic   w_advance;

    // Input register
    jhs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_if (i_byte_if),
        .i_advance (w_advance),
        .o_stage   (w_stage)
    );

    // Parse step and result register
    jhs_parser #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (w_stage),
        .o_advance   (w_advance),
        .o_result_if (o_result_if)
    );

endmodule

FILE: rtl/jhs_in_stage.sv
`timescale 1ns / 1ps
// Input register of the scanner: captures one byte word per handshake.
// Depends on jhs_pkg and jhs_byte_if.
module jhs_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jhs_byte_if.sink         i_byte_if,
    input  logic             i_advance,
    output jhs_pkg::t_stage  o_stage
);
    import jhs_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // Take a word when empty or when the parser drains the held one
    assign i_byte_if.ready = !r_valid || i_advance;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte_if.valid && i_byte_if.ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_byte_if.valid && i_byte_if.ready) begin
            r_word <= i_byte_if.data;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.word  = r_word;

endmodule

FILE: rtl/jhs_parser.sv
`timescale 1ns / 1ps
// Parse state, combinational header/pixel step and result register.
// Depends on jhs_pkg and jhs_result_if.
module jhs_parser #(
    parameter int unsigned WINDOW_BYTES = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  jhs_pkg::t_stage  i_stage,
    output logic             o_advance,
    jhs_result_if.source     o_result_if
);
    import jhs_pkg::*;

    localparam logic [12:0] WINDOW_END = 13'(WINDOW_BYTES);

    logic        r_thumb_only;
    logic [11:0] r_pos,  n_pos,  c_pos;
    t_phase      r_phase, n_phase, c_phase;
    logic [4:0]  r_fidx, n_fidx, c_fidx;
    logic        r_len_hi_nz, n_len_hi_nz, c_len_hi_nz;
    logic [15:0] r_w, n_w, c_w;
    logic [15:0] r_h, n_h, c_h;
    logic [7:0]  r_comps, n_comps, c_comps;
    logic [7:0]  r_s0, n_s0, c_s0;
    logic [7:0]  r_s1, n_s1, c_s1;
    logic [7:0]  r_s2, n_s2, c_s2;
    logic [1:0]  r_cphase, n_cphase, c_cphase;
    logic [9:0]  r_part, n_part, c_part;
    logic [15:0] r_left, n_left, c_left;

    logic        r_out_valid;
    t_out_word   r_out;

    logic        w_has;
    t_out_word   w_res;
    logic [7:0]  w_b;
    logic [4:0]  w_sof_idx;
    logic [15:0] w_left_dec;
    logic [11:0] w_off;
    logic [15:0] w_area;

    // Advance when the result register is free or being taken
    assign o_advance = !r_out_valid || o_result_if.ready;

    assign w_b        = i_stage.word.data_byte;
    assign w_sof_idx  = c_fidx + 5'd1;
    assign w_left_dec = c_left - 16'd1;
    assign w_off      = (c_pos == POS_MAX) ? POS_MAX : c_pos + 12'd1;
    assign w_area     = {8'd0, c_w[7:0]} * {8'd0, w_b};

    // Restart clears the scan state before the byte is parsed
    always_comb begin
        if (i_stage.word.first_byte) begin
            c_pos = '0; c_phase = PH_SCAN; c_fidx = '0; c_len_hi_nz = 1'b0;
            c_w = '0; c_h = '0; c_comps = '0; c_s0 = '0; c_s1 = '0; c_s2 = '0;
            c_cphase = '0; c_part = '0; c_left = '0;
        end else begin
            c_pos = r_pos; c_phase = r_phase; c_fidx = r_fidx;
            c_len_hi_nz = r_len_hi_nz;
            c_w = r_w; c_h = r_h; c_comps = r_comps;
            c_s0 = r_s0; c_s1 = r_s1; c_s2 = r_s2;
            c_cphase = r_cphase; c_part = r_part; c_left = r_left;
        end
    end

    // Parse one byte
    always_comb begin
        n_pos = c_pos; n_phase = c_phase; n_fidx = c_fidx; n_len_hi_nz = c_len_hi_nz;
        n_w = c_w; n_h = c_h; n_comps = c_comps;
        n_s0 = c_s0; n_s1 = c_s1; n_s2 = c_s2;
        n_cphase = c_cphase; n_part = c_part; n_left = c_left;
        w_has = 1'b0;
        w_res = '0;

        unique case (c_phase)
            PH_SCAN: begin
                if ({1'b0, c_pos} >= WINDOW_END) begin
                    w_has   = 1'b1;
                    w_res   = jhs_report(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
                    n_phase = PH_DONE;
                end else if (w_b == MARK_PREFIX) begin
                    n_phase = PH_MARK;
                end
            end
            PH_MARK: begin
                if (w_b == MARK_APP0) begin
                    n_phase = PH_LENHI;
                end else if (w_b == MARK_SOF0) begin
                    n_phase = PH_SOF;
                    n_fidx  = '0;
                end else begin
                    n_phase = PH_SCAN;
                end
            end
            PH_LENHI: begin
                n_len_hi_nz = (w_b != 8'd0);
                n_phase     = PH_LENLO;
            end
            PH_LENLO: begin
                if (!c_len_hi_nz && w_b <= APP0_MIN_LEN) begin
                    n_phase = PH_SCAN;
                end else begin
                    n_phase = PH_APP0;
                    n_fidx  = '0;
                end
            end
            PH_APP0: begin
                // Check identifier and version, then pick up thumbnail size
                if (c_fidx < APP0_IDENT_LEN) begin
                    if (w_b != jhs_ident_byte(c_fidx[2:0])) begin
                        w_has   = 1'b1;
                        w_res   = jhs_report(ST_BAD_ID, '0, '0, '0, '0, '0, '0, '0);
                        n_phase = PH_DONE;
                    end else begin
                        n_fidx = c_fidx + 5'd1;
                    end
                end else if (c_fidx == APP0_MINOR_IDX) begin
                    if (w_b > JFIF_MINOR_MAX) begin
                        w_has   = 1'b1;
                        w_res   = jhs_report(ST_BAD_ID, '0, '0, '0, '0, '0, '0, '0);
                        n_phase = PH_DONE;
                    end else begin
                        n_fidx = c_fidx + 5'd1;
                    end
                end else if (c_fidx == APP0_XTH_IDX) begin
                    n_w    = {8'd0, w_b};
                    n_fidx = c_fidx + 5'd1;
                end else if (c_fidx == APP0_YTH_IDX) begin
                    n_h = {8'd0, w_b};
                    if (c_w == 16'd0 || w_b == 8'd0) begin
                        n_phase = PH_SCAN;
                    end else begin
                        w_has    = 1'b1;
                        w_res    = jhs_report(ST_THUMB, c_w, {8'd0, w_b}, '0, '0, '0, '0,
                                              w_off);
                        n_left   = w_area;
                        n_cphase = '0;
                        n_part   = '0;
                        n_phase  = PH_PIXELS;
                    end
                end else begin
                    n_fidx = c_fidx + 5'd1;
                end
            end
            PH_SOF: begin
                n_fidx = w_sof_idx;
                if (w_sof_idx == SOF_HEIGHT_HI) begin
                    n_h = {w_b, 8'd0};
                end else if (w_sof_idx == SOF_HEIGHT_LO) begin
                    n_h = {c_h[15:8], c_h[7:0] | w_b};
                end else if (w_sof_idx == SOF_WIDTH_HI) begin
                    n_w = {w_b, 8'd0};
                end else if (w_sof_idx == SOF_WIDTH_LO) begin
                    n_w = {c_w[15:8], c_w[7:0] | w_b};
                end else if (w_sof_idx == SOF_SAMP0) begin
                    n_s0 = w_b;
                end else if (w_sof_idx == SOF_SAMP1) begin
                    n_s1 = w_b;
                end else if (w_sof_idx == SOF_SAMP2) begin
                    n_s2 = w_b;
                end else if (w_sof_idx == SOF_NCOMP) begin
                    n_comps = w_b;
                end
                // Frame or no-size report when the count is not three or the list is complete
                if ((w_sof_idx == SOF_NCOMP && w_b != SOF_FULL_COMPS) ||
                    w_sof_idx == SOF_SAMP2) begin
                    w_has   = 1'b1;
                    n_phase = PH_DONE;
                    if (n_w == 16'd0 || n_h == 16'd0 || r_thumb_only) begin
                        w_res = jhs_report(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
                    end else begin
                        w_res = jhs_report(ST_FRAME, n_w, n_h, n_comps,
                                           n_s0, n_s1, n_s2, '0);
                    end
                end
            end
            PH_PIXELS: begin
                // Keep top five bits of each channel
                unique case (c_cphase)
                    2'd0: begin
                        n_part   = {5'd0, w_b[7:3]};
                        n_cphase = 2'd1;
                    end
                    2'd1: begin
                        n_part   = {c_part[4:0], w_b[7:3]};
                        n_cphase = 2'd2;
                    end
                    default: begin
                        n_left            = w_left_dec;
                        n_cphase          = 2'd0;
                        w_has             = 1'b1;
                        w_res.result_kind = KIND_PIXEL;
                        w_res.pixel_value = {c_part, w_b[7:3]};
                        w_res.last_pixel  = (w_left_dec == 16'd0);
                        if (w_left_dec == 16'd0) begin
                            n_phase = PH_DONE;
                        end
                    end
                endcase
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // End of file inside the search or a header gives no-size report
        if (i_stage.word.last_byte) begin
            if (!w_has && n_phase != PH_PIXELS && n_phase != PH_DONE) begin
                w_has = 1'b1;
                w_res = jhs_report(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
            end
            n_phase = PH_DONE;
        end

        if (c_pos != POS_MAX) begin
            n_pos = c_pos + 12'd1;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thumb_only <= 1'b0;
        end else if (i_cfg_we) begin
            r_thumb_only <= i_cfg_wdata;
        end
    end

    // Commit parse state on each consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_phase <= PH_SCAN; r_fidx <= '0; r_len_hi_nz <= 1'b0;
            r_w <= '0; r_h <= '0; r_comps <= '0;
            r_s0 <= '0; r_s1 <= '0; r_s2 <= '0;
            r_cphase <= '0; r_part <= '0; r_left <= '0;
        end else if (o_advance && i_stage.valid) begin
            r_pos <= n_pos; r_phase <= n_phase; r_fidx <= n_fidx;
            r_len_hi_nz <= n_len_hi_nz;
            r_w <= n_w; r_h <= n_h; r_comps <= n_comps;
            r_s0 <= n_s0; r_s1 <= n_s1; r_s2 <= n_s2;
            r_cphase <= n_cphase; r_part <= n_part; r_left <= n_left;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_stage.valid && w_has;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (o_advance && i_stage.valid && w_has) begin
            r_out <= w_res;
        end
    end

    assign o_result_if.valid = r_out_valid;
    assign o_result_if.data  = r_out;

endmodule

FILE: dv/jfif_header_scan_thumbnail_unpack_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the JFIF header scanner: builds byte streams of whole and broken
// JPEG files, predicts every report and RGB555 pixel word, and checks each one in order.
// Depends on jhs_pkg, jhs_if and the scanner core under rtl/.
module jfif_header_scan_thumbnail_unpack_core_tb;
    import jhs_pkg::*;

    localparam int SCAN_WINDOW  = 2048;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [7:0]  MARK_SOI = 8'hD8;
    localparam logic [47:0] JFIF_TAG = 48'h4A_46_49_46_00_01;

    localparam logic [1:0] RGB_RED   = 2'd0;
    localparam logic [1:0] RGB_GREEN = 2'd1;
    localparam logic [1:0] RGB_BLUE  = 2'd2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic drv_valid = 1'b0;
    t_in_word drv_data = '0;
    logic mon_ready = 1'b0;

    jhs_byte_if   byte_ch ();
    jhs_result_if res_ch ();

    assign byte_ch.valid = drv_valid;
    assign byte_ch.data  = drv_data;
    assign res_ch.ready  = mon_ready;

    jfif_header_scan_thumbnail_unpack_core #(
        .WINDOW_BYTES (SCAN_WINDOW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_byte_if   (byte_ch),
        .o_result_if (res_ch)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stimulus and expectation stores
    t_in_word   pending[$];
    t_out_word  exp_results[$];
    logic [7:0] fbuf[$];
    int         errors = 0;
    int         quiet_cycles = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    bit         steady_tail = 1'b0;

    // Scanner state as predicted by the bench
    bit          thumb_only = 1'b0;
    logic [11:0] byte_pos = '0;
    t_phase      scan_ph = PH_SCAN;
    logic [4:0]  fld = '0;
    logic [15:0] seg_len = '0;
    logic [15:0] hold_w = '0;
    logic [15:0] hold_h = '0;
    logic [7:0]  hold_comps = '0;
    logic [7:0]  hold_samp[3] = '{default: '0};
    logic [1:0]  rgb_ph = RGB_RED;
    logic [9:0]  rgb_part = '0;
    logic [15:0] pix_left = '0;

    function automatic void clear_scan();
        byte_pos   = '0;
        scan_ph    = PH_SCAN;
        fld        = '0;
        seg_len    = '0;
        hold_w     = '0;
        hold_h     = '0;
        hold_comps = '0;
        hold_samp  = '{default: '0};
        rgb_ph     = RGB_RED;
        rgb_part   = '0;
        pix_left   = '0;
    endfunction

    function automatic t_out_word header_word(t_status st, logic [15:0] w, logic [15:0] h,
                                              logic [7:0] nc, logic [7:0] s0, logic [7:0] s1,
                                              logic [7:0] s2, logic [11:0] off);
        t_out_word r;
        r                 = '0;
        r.result_kind     = KIND_REPORT;
        r.status          = st;
        r.image_width     = w;
        r.image_height    = h;
        r.component_count = nc;
        r.sampling_first  = s0;
        r.sampling_second = s1;
        r.sampling_third  = s2;
        r.thumb_offset    = off;
        return r;
    endfunction

    // Frame header complete: report size or no usable size
    function automatic t_out_word close_frame();
        scan_ph = PH_DONE;
        if (hold_w == 0 || hold_h == 0 || thumb_only)
            return header_word(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
        return header_word(ST_FRAME, hold_w, hold_h, hold_comps,
                           hold_samp[0], hold_samp[1], hold_samp[2], '0);
    endfunction

    // Advance the predicted scanner by one byte; return 1 when it yields a word
    function automatic bit scan_byte(input t_in_word w, output t_out_word r);
        logic [7:0]  b;
        logic [11:0] off;
        bit          has;
        bit          bad;
        int          k;
        b   = w.data_byte;
        has = 1'b0;
        bad = 1'b0;
        r   = '0;
        if (w.first_byte)
            clear_scan();
        k = fld;
        case (scan_ph)
            PH_SCAN: begin
                if (byte_pos >= SCAN_WINDOW) begin
                    r = header_word(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
                    scan_ph = PH_DONE;
                    has = 1'b1;
                end else if (b == MARK_PREFIX) begin
                    scan_ph = PH_MARK;
                end
            end
            PH_MARK: begin
                if (b == MARK_APP0) begin
                    scan_ph = PH_LENHI;
                end else if (b == MARK_SOF0) begin
                    scan_ph = PH_SOF;
                    fld = '0;
                end else begin
                    scan_ph = PH_SCAN;
                end
            end
            PH_LENHI: begin
                seg_len = {b, 8'h00};
                scan_ph = PH_LENLO;
            end
            PH_LENLO: begin
                seg_len[7:0] = b;
                if (seg_len <= {8'h00, APP0_MIN_LEN}) begin
                    scan_ph = PH_SCAN;
                end else begin
                    scan_ph = PH_APP0;
                    fld = '0;
                end
            end
            PH_APP0: begin
                if (fld < APP0_IDENT_LEN)
                    bad = (b != JFIF_TAG[8*(5-k) +: 8]);
                else if (fld == APP0_MINOR_IDX)
                    bad = (b > JFIF_MINOR_MAX);
                else if (fld == APP0_XTH_IDX)
                    hold_w = {8'h00, b};
                else if (fld == APP0_YTH_IDX)
                    hold_h = {8'h00, b};
                if (bad) begin
                    r = header_word(ST_BAD_ID, '0, '0, '0, '0, '0, '0, '0);
                    scan_ph = PH_DONE;
                    has = 1'b1;
                end else if (fld == APP0_YTH_IDX) begin
                    // Zero-size thumbnail resumes the marker search
                    if (hold_w == 0 || hold_h == 0) begin
                        scan_ph = PH_SCAN;
                    end else begin
                        off = (byte_pos == POS_MAX) ? POS_MAX : byte_pos + 12'd1;
                        r = header_word(ST_THUMB, hold_w, hold_h, '0, '0, '0, '0, off);
                        pix_left = hold_w * hold_h;
                        rgb_ph = RGB_RED;
                        rgb_part = '0;
                        scan_ph = PH_PIXELS;
                        has = 1'b1;
                    end
                end else begin
                    fld = fld + 5'd1;
                end
            end
            PH_SOF: begin
                fld = fld + 5'd1;
                case (fld)
                    SOF_HEIGHT_HI: hold_h = {b, 8'h00};
                    SOF_HEIGHT_LO: hold_h = hold_h | {8'h00, b};
                    SOF_WIDTH_HI:  hold_w = {b, 8'h00};
                    SOF_WIDTH_LO:  hold_w = hold_w | {8'h00, b};
                    SOF_NCOMP: begin
                        hold_comps = b;
                        if (b != SOF_FULL_COMPS) begin
                            r = close_frame();
                            has = 1'b1;
                        end
                    end
                    SOF_SAMP0: hold_samp[0] = b;
                    SOF_SAMP1: hold_samp[1] = b;
                    SOF_SAMP2: begin
                        hold_samp[2] = b;
                        r = close_frame();
                        has = 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_PIXELS: begin
                // Keep the top five bits of each channel
                if (rgb_ph == RGB_RED) begin
                    rgb_part = {5'd0, b[7:3]};
                    rgb_ph = RGB_GREEN;
                end else if (rgb_ph == RGB_GREEN) begin
                    rgb_part = {rgb_part[4:0], b[7:3]};
                    rgb_ph = RGB_BLUE;
                end else begin
                    pix_left = pix_left - 16'd1;
                    rgb_ph = RGB_RED;
                    r.result_kind = KIND_PIXEL;
                    r.pixel_value = {rgb_part, b[7:3]};
                    r.last_pixel = (pix_left == 0);
                    if (pix_left == 0)
                        scan_ph = PH_DONE;
                    has = 1'b1;
                end
            end
            default: scan_ph = PH_DONE;
        endcase
        // End of file inside the search or a header gives no usable size
        if (w.last_byte) begin
            if (!has && scan_ph != PH_PIXELS && scan_ph != PH_DONE) begin
                r = header_word(ST_NO_SIZE, '0, '0, '0, '0, '0, '0, '0);
                has = 1'b1;
            end
            scan_ph = PH_DONE;
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 12'd1;
        return has;
    endfunction

    // Random idle bursts, with quiet stretches in between
    function automatic int idle_burst(inout int stretch, inout bit calm);
        if (stretch == 0) begin
            stretch = $urandom_range(16, 96);
            calm = ($urandom_range(0, 3) == 0);
        end
        stretch--;
        if (calm || steady_tail || $urandom_range(0, 5) != 0)
            return 0;
        return $urandom_range(1, 8);
    endfunction

    task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(t_out_word got);
        t_out_word want;
        if (exp_results.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, got);
            errors++;
        end else begin
            want = exp_results.pop_front();
            cmp_field("result_kind", want.result_kind, got.result_kind);
            cmp_field("status", want.status, got.status);
            cmp_field("image_width", want.image_width, got.image_width);
            cmp_field("image_height", want.image_height, got.image_height);
            cmp_field("component_count", want.component_count, got.component_count);
            cmp_field("sampling_first", want.sampling_first, got.sampling_first);
            cmp_field("sampling_second", want.sampling_second, got.sampling_second);
            cmp_field("sampling_third", want.sampling_third, got.sampling_third);
            cmp_field("thumb_offset", want.thumb_offset, got.thumb_offset);
            cmp_field("pixel_value", want.pixel_value, got.pixel_value);
            cmp_field("last_pixel", want.last_pixel, got.last_pixel);
        end
    endtask

    // Byte driver: predict each accepted word, then offer the next one
    int tx_gap = 0;
    int tx_stretch = 0;
    bit tx_calm = 1'b0;
    always @(posedge i_clk) begin
        t_out_word r;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && byte_ch.ready) begin
                if (scan_byte(drv_data, r))
                    exp_results.push_back(r);
            end
            if (!drv_valid || byte_ch.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    drv_valid <= 1'b0;
                end else if (pending.size() > 0) begin
                    drv_valid <= 1'b1;
                    drv_data <= pending.pop_front();
                    tx_gap = idle_burst(tx_stretch, tx_calm);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check accepted words, drive ready with stalls
    int rx_gap = 0;
    int rx_stretch = 0;
    bit rx_calm = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (res_ch.valid && mon_ready)
                check_result(res_ch.data);
            if (rx_gap > 0) begin
                rx_gap--;
                mon_ready <= 1'b0;
            end else if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                rx_gap = LONG_HOLD - 1;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
                rx_gap = idle_burst(rx_stretch, rx_calm);
            end
        end
    end

    // Watchdog on cycles with no word moved on either side
    always @(posedge i_clk) begin
        if ((drv_valid && byte_ch.ready) || (res_ch.valid && mon_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // File builders: append bytes to fbuf
    task automatic start_file();
        fbuf.delete();
        fbuf.push_back(MARK_PREFIX);
        fbuf.push_back(MARK_SOI);
    endtask

    // Noise: any marker prefix is followed by a code that opens no segment
    task automatic put_noise(int n);
        int cnt;
        logic [7:0] v;
        cnt = 0;
        while (cnt < n) begin
            v = $urandom_range(0, 255);
            fbuf.push_back(v);
            cnt++;
            if (v == MARK_PREFIX) begin
                v = $urandom_range(0, 255);
                if (v == MARK_APP0 || v == MARK_SOF0)
                    v = MARK_SOI;
                fbuf.push_back(v);
                cnt++;
            end
        end
    endtask

    task automatic put_plain(int n);
        repeat (n) fbuf.push_back(8'($urandom_range(0, 254)));
    endtask

    task automatic put_short_app0(logic [15:0] len);
        fbuf.push_back(MARK_PREFIX);
        fbuf.push_back(MARK_APP0);
        fbuf.push_back(len[15:8]);
        fbuf.push_back(len[7:0]);
        put_noise($urandom_range(0, len));
    endtask

    // APP0 segment; bad_at picks an identifier byte (6 = minor version) to corrupt
    task automatic put_app0(logic [15:0] len, int bad_at, logic [7:0] tw, logic [7:0] th,
                            bit with_pixels);
        int i;
        int npix;
        logic [7:0] v;
        fbuf.push_back(MARK_PREFIX);
        fbuf.push_back(MARK_APP0);
        fbuf.push_back(len[15:8]);
        fbuf.push_back(len[7:0]);
        for (i = 0; i < 6; i++) begin
            v = JFIF_TAG[8*(5-i) +: 8];
            if (i == bad_at)
                v = v ^ 8'($urandom_range(1, 255));
            fbuf.push_back(v);
        end
        v = $urandom_range(0, 1);
        if (bad_at == 6)
            v = $urandom_range(2, 255);
        fbuf.push_back(v);
        if (bad_at >= 0)
            return;
        repeat (5) fbuf.push_back(8'($urandom));
        fbuf.push_back(tw);
        fbuf.push_back(th);
        npix = tw * th;
        if (with_pixels) begin
            for (i = 0; i < 3 * npix; i++) begin
                v = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
                fbuf.push_back(v);
            end
        end
    endtask

    task automatic put_sof(logic [15:0] h, logic [15:0] w, logic [7:0] nc);
        fbuf.push_back(MARK_PREFIX);
        fbuf.push_back(MARK_SOF0);
        repeat (3) fbuf.push_back(8'($urandom));
        fbuf.push_back(h[15:8]);
        fbuf.push_back(h[7:0]);
        fbuf.push_back(w[15:8]);
        fbuf.push_back(w[7:0]);
        fbuf.push_back(nc);
        if (nc == SOF_FULL_COMPS)
            repeat (9) fbuf.push_back(8'($urandom));
    endtask

    task automatic cut_file(int idx);
        while (fbuf.size() > idx + 1)
            fbuf.delete(fbuf.size() - 1);
    endtask

    // Move fbuf into the pending queue, marking its first and last byte
    task automatic emit_file(bit with_first, bit with_last);
        int i;
        t_in_word w;
        for (i = 0; i < fbuf.size(); i++) begin
            w.data_byte  = fbuf[i];
            w.first_byte = with_first && (i == 0);
            w.last_byte  = with_last && (i == fbuf.size() - 1);
            pending.push_back(w);
        end
        fbuf.delete();
    endtask

    function automatic logic [7:0] thumb_dim();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(4, 8);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] frame_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return $urandom_range(1, 65535);
    endfunction

    function automatic logic [7:0] comp_count();
        if ($urandom_range(0, 9) < 7)
            return SOF_FULL_COMPS;
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [15:0] app0_len();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 16'd17;
        if (r == 1)
            return 16'hFFFF;
        return $urandom_range(17, 65535);
    endfunction

    // One random file: mostly well formed, some broken, truncated or noise
    task automatic random_file(output int n);
        int kind;
        int mode;
        int i;
        logic [7:0] tw;
        logic [7:0] th;
        t_in_word junk;
        kind = $urandom_range(0, 11);
        start_file();
        put_noise($urandom_range(0, 4));
        if ($urandom_range(0, 3) == 0)
            put_short_app0(16'($urandom_range(0, 16)));
        case (kind)
            0, 1, 2, 3, 4: put_app0(app0_len(), -1, thumb_dim(), thumb_dim(), 1'b1);
            5: begin
                tw = $urandom_range(0, 1) ? 8'd0 : thumb_dim();
                th = (tw != 0) ? 8'd0 : 8'($urandom_range(0, 3));
                put_app0(app0_len(), -1, tw, th, 1'b0);
                put_noise($urandom_range(0, 3));
                put_sof(frame_dim(), frame_dim(), comp_count());
            end
            6, 7, 8: put_sof(frame_dim(), frame_dim(), comp_count());
            9: begin
                put_app0(app0_len(), $urandom_range(0, 6), 8'd1, 8'd1, 1'b0);
                put_noise($urandom_range(0, 6));
            end
            default: put_noise($urandom_range(4, 30));
        endcase
        mode = $urandom_range(0, 9);
        if (mode >= 7)
            cut_file($urandom_range(0, fbuf.size() - 1));
        n = fbuf.size();
        emit_file(1'b1, mode != 6 && mode != 9);
        // Trailing bytes that a finished scan drops
        if ($urandom_range(0, 4) == 0) begin
            for (i = 0; i < $urandom_range(1, 6); i++) begin
                junk.data_byte  = $urandom;
                junk.first_byte = 1'b0;
                junk.last_byte  = $urandom_range(0, 1);
                pending.push_back(junk);
            end
        end
    endtask

    task automatic random_files(int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget) begin
            random_file(n);
            sent += n;
        end
    endtask

    // Wait until every byte is taken and every word has come, then let the core settle
    task automatic drain();
        while (pending.size() != 0 || drv_valid || exp_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_thumb_only(bit v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        thumb_only = v;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First file after reset carries no restart mark; pixel bytes at both extremes
        start_file();
        put_app0(16'd17, -1, 8'd2, 8'd1, 1'b0);
        repeat (3) fbuf.push_back(8'hFF);
        repeat (3) fbuf.push_back(8'h00);
        emit_file(1'b0, 1'b1);

        // Short APP0 segments are skipped; frame at maximum size
        start_file();
        put_short_app0(16'd16);
        put_short_app0(16'd0);
        put_sof(16'hFFFF, 16'hFFFF, SOF_FULL_COMPS);
        emit_file(1'b1, 1'b1);

        // Zero thumbnail sizes resume the search; single-component frame
        start_file();
        put_app0(16'hFFFF, -1, 8'd0, 8'd5, 1'b0);
        put_app0(16'd17, -1, 8'd5, 8'd0, 1'b0);
        put_sof(16'd1, 16'd1, 8'd1);
        emit_file(1'b1, 1'b1);

        // Bad identifier byte, bad minor version, trailing bytes dropped
        start_file();
        put_app0(16'd100, 0, 8'd1, 8'd1, 1'b0);
        put_noise(4);
        emit_file(1'b1, 1'b1);
        start_file();
        put_app0(16'd100, 6, 8'd1, 8'd1, 1'b0);
        emit_file(1'b1, 1'b0);

        // Frames with zero width, no components and 255 components
        start_file();
        put_sof(16'd480, 16'd0, SOF_FULL_COMPS);
        emit_file(1'b1, 1'b1);
        start_file();
        put_sof(16'd8, 16'd8, 8'd0);
        emit_file(1'b1, 1'b1);
        start_file();
        put_sof(16'd8, 16'd8, 8'd255);
        emit_file(1'b1, 1'b1);

        // Truncation during the search, inside a header and among the pixels
        start_file();
        put_noise(5);
        emit_file(1'b1, 1'b1);
        start_file();
        put_app0(16'd40, -1, 8'd2, 8'd2, 1'b1);
        cut_file(10);
        emit_file(1'b1, 1'b1);
        start_file();
        put_app0(16'd40, -1, 8'd2, 8'd2, 1'b1);
        cut_file(fbuf.size() - 5);
        emit_file(1'b1, 1'b1);

        // Restart in the middle of a frame header, then a widest thumbnail
        start_file();
        put_sof(16'd64, 16'd64, SOF_FULL_COMPS);
        cut_file(8);
        emit_file(1'b1, 1'b0);
        start_file();
        put_app0(16'd17, -1, 8'd255, 8'd1, 1'b1);
        emit_file(1'b1, 1'b1);

        // Window runs out while searching
        fbuf.delete();
        put_plain(SCAN_WINDOW + 50);
        emit_file(1'b1, 1'b1);

        // Marker on the last searched positions still opens the segment
        fbuf.delete();
        put_plain(SCAN_WINDOW - 2);
        put_app0(16'd17, -1, 8'd1, 8'd1, 1'b1);
        emit_file(1'b1, 1'b1);
        drain();

        // Thumbnail-only mode: frames give no usable size, thumbnails still report
        write_thumb_only(1'b1);
        start_file();
        put_sof(16'd100, 16'd200, SOF_FULL_COMPS);
        emit_file(1'b1, 1'b1);
        start_file();
        put_app0(16'd17, -1, 8'd1, 8'd2, 1'b1);
        emit_file(1'b1, 1'b1);
        random_files(150);
        drain();

        // Long receiver hold-off while bytes keep coming, then a sender pause
        write_thumb_only(1'b0);
        random_files(150);
        hold_req++;
        drain();
        random_files(100);
        drain();

        // Last part in thumbnail-only mode, the final files without any idling
        write_thumb_only(1'b1);
        random_files(100);
        while (pending.size() != 0)
            @(negedge i_clk);
        steady_tail = 1'b1;
        random_files(100);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
